// ----- src/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
package bcc_pkg;

	// Number of keys served by the block
	localparam int unsigned NUM_KEYS = 5;

	// Field and register widths
	localparam int unsigned KEY_IDX_W = 3;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned EVT_W = 3;
	localparam int unsigned CFG_W = 16;

	// Per-key press phase
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_DEB1      = 3'd1,
		PH_HOLD      = 3'd2,
		PH_REL       = 3'd3,
		PH_DEB2      = 3'd4,
		PH_WAIT_DBL  = 3'd5,
		PH_WAIT_LONG = 3'd6
	} phase_t;

	// Event codes
	typedef enum logic [EVT_W-1:0] {
		EV_NONE     = 3'd0,
		EV_SINGLE   = 3'd1,
		EV_DOUBLE   = 3'd2,
		EV_LONG     = 3'd3,
		EV_LONG_REL = 3'd4
	} event_t;

	// Operation codes
	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// Configuration register indexes
	localparam logic CFG_LONG_PRESS    = 1'b0;
	localparam logic CFG_SHORT_RELEASE = 1'b1;

	// Item handed from the input stage to the key bank
	typedef struct packed {
		logic                 fire;
		op_t                  op;
		logic [KEY_IDX_W-1:0] key;
		logic                 act;
	} key_req_t;

	// Tick counter per key and thresholds
	typedef logic [CNT_W-1:0] count_t;

endpackage

// ----- src/bcc_fsm.sv -----
// Next-state logic of the per-key press classifier.
module bcc_fsm (
	input  bcc_pkg::phase_t phase,
	input  bcc_pkg::count_t count,
	input  logic            act,
	input  bcc_pkg::count_t long_press_ticks,
	input  bcc_pkg::count_t short_release_ticks,
	output bcc_pkg::phase_t phase_nxt,
	output bcc_pkg::count_t count_nxt,
	output bcc_pkg::event_t evt
);
	import bcc_pkg::*;

	count_t count_inc;

	// Saturating tick count
	assign count_inc = (count == '1) ? count : count + count_t'(1);

	always_comb begin
		phase_nxt = phase;
		count_nxt = count;
		evt       = EV_NONE;
		unique case (phase)
			PH_DEB1: begin
				if (act) begin
					phase_nxt = PH_HOLD;
					count_nxt = '0;
				end else begin
					phase_nxt = PH_IDLE;
				end
			end
			PH_HOLD: begin
				if (!act) begin
					phase_nxt = PH_REL;
					count_nxt = '0;
				end else if (count > long_press_ticks) begin
					evt       = EV_LONG;
					phase_nxt = PH_WAIT_LONG;
				end else begin
					count_nxt = count_inc;
				end
			end
			PH_REL: begin
				if (act) begin
					phase_nxt = PH_DEB2;
				end else if (count > short_release_ticks) begin
					evt       = EV_SINGLE;
					phase_nxt = PH_IDLE;
				end else begin
					count_nxt = count_inc;
				end
			end
			PH_DEB2: begin
				// a one-tick bounce drops back to released, count kept
				if (act) begin
					evt       = EV_DOUBLE;
					phase_nxt = PH_WAIT_DBL;
				end else begin
					phase_nxt = PH_REL;
				end
			end
			PH_WAIT_DBL: begin
				if (!act) phase_nxt = PH_IDLE;
			end
			PH_WAIT_LONG: begin
				if (!act) begin
					evt       = EV_LONG_REL;
					phase_nxt = PH_IDLE;
				end
			end
			default: begin
				// idle and the unused code
				phase_nxt = act ? PH_DEB1 : PH_IDLE;
			end
		endcase
	end

endmodule

// ----- src/bcc_bank.sv -----
// Per-key state registers, latched events and result selection.
module bcc_bank (
	input  logic              clk,
	input  logic              arst_n,
	input  bcc_pkg::key_req_t req,
	input  bcc_pkg::count_t   long_press_ticks,
	input  bcc_pkg::count_t   short_release_ticks,
	output bcc_pkg::event_t   evt_res
);
	import bcc_pkg::*;

	phase_t phase_q   [NUM_KEYS];
	count_t count_q   [NUM_KEYS];
	event_t latched_q [NUM_KEYS];

	logic   [NUM_KEYS-1:0] sel;
	logic   in_range;
	phase_t cur_phase;
	count_t cur_count;
	event_t cur_latched;
	phase_t phase_nxt;
	count_t count_nxt;
	event_t scan_evt;

	// Key decode and read of the selected key's state
	always_comb begin
		cur_phase   = PH_IDLE;
		cur_count   = '0;
		cur_latched = EV_NONE;
		for (int k = 0; k < NUM_KEYS; k++) begin
			sel[k] = (req.key == KEY_IDX_W'(k));
			if (sel[k]) begin
				cur_phase   = phase_q[k];
				cur_count   = count_q[k];
				cur_latched = latched_q[k];
			end
		end
	end

	assign in_range = |sel;

	bcc_fsm u_fsm (
		.phase               (cur_phase),
		.count               (cur_count),
		.act                 (req.act),
		.long_press_ticks    (long_press_ticks),
		.short_release_ticks (short_release_ticks),
		.phase_nxt           (phase_nxt),
		.count_nxt           (count_nxt),
		.evt                 (scan_evt)
	);

	// Result of the item: latched event on read, raised event on scan, none for a key out of range
	always_comb begin
		evt_res = EV_NONE;
		if (in_range) begin
			if (req.op == OP_READ) evt_res = cur_latched;
			else evt_res = scan_evt;
		end
	end

	// State update of the selected key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				phase_q[k]   <= PH_IDLE;
				count_q[k]   <= '0;
				latched_q[k] <= EV_NONE;
			end
		end else if (req.fire) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (sel[k]) begin
					if (req.op == OP_READ) begin
						latched_q[k] <= EV_NONE;
					end else begin
						phase_q[k] <= phase_nxt;
						count_q[k] <= count_nxt;
						if (scan_evt != EV_NONE) latched_q[k] <= scan_evt;
					end
				end
			end
		end
	end

endmodule

// ----- src/button_click_classifier_core.sv -----
// Button click classifier: input stage, key bank and result register.
// An accepted item waits in the input stage; its result is then registered in the output register.
// Throughput: one item per cycle while the receiver does not stall; the per-key state update is one short FSM step.
// A waiting result does not block the input stage, which holds one more item.
// Reset clears all key phases, counters and latched events, and loads the
// thresholds with 1000 (long press) and 300 (short release).
module button_click_classifier_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [bcc_pkg::KEY_IDX_W-1:0]  key_index,
	input  logic                           key_active,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bcc_pkg::EVT_W-1:0]      event_res,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [bcc_pkg::CFG_W-1:0]      cfg_data
);
	import bcc_pkg::*;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [KEY_IDX_W-1:0] key_s1;
	logic                 act_s1;
	logic                 advance;
	logic                 in_fire;
	key_req_t             req;
	event_t               evt_res;
	count_t               long_press_q;
	count_t               short_release_q;
	logic                 out_valid_q;
	event_t               event_q;

	// Handshake: the input stage moves on when the output register is free or drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q    <= count_t'(1000);
			short_release_q <= count_t'(300);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LONG_PRESS:    long_press_q    <= cfg_data;
				CFG_SHORT_RELEASE: short_release_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= op_t'(operation);
			key_s1 <= key_index;
			act_s1 <= key_active;
		end
	end

	// Key bank
	assign req.fire = valid_s1 && advance;
	assign req.op   = op_s1;
	assign req.key  = key_s1;
	assign req.act  = act_s1;

	bcc_bank u_bank (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req                 (req),
		.long_press_ticks    (long_press_q),
		.short_release_ticks (short_release_q),
		.evt_res             (evt_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.fire) event_q <= evt_res;
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

	// Assertions
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		req.fire |=> out_valid_q)
		else $error("processed item did not reach output register");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (event_q <= EV_LONG_REL))
		else $error("result holds an undefined event code");

endmodule

// ----- test/tb.sv -----
// Testbench for button_click_classifier_core: scan and read items checked against a key model.
`timescale 1ns / 1ps

module tb;
	import bcc_pkg::*;

	// Receiver stall patterns
	localparam int STALL_NONE     = 0;
	localparam int STALL_LIGHT    = 1;
	localparam int STALL_PERIODIC = 2;
	localparam int STALL_HEAVY    = 3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 operation;
	logic [KEY_IDX_W-1:0] key_index;
	logic                 key_active;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [EVT_W-1:0]     event_res;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Key model state and thresholds
	phase_t key_phase [NUM_KEYS];
	count_t key_ticks [NUM_KEYS];
	event_t key_latch [NUM_KEYS];
	count_t long_limit;
	count_t short_limit;

	// Predicted events waiting for their result
	event_t pending_events [$];
	event_t next_event;

	int     error_count = 0;
	int     useful_items = 0;
	int     stall_mode = STALL_NONE;
	int     holdoff_len = 0;
	int     stall_phase = 0;
	bit     burst_mode = 1'b0;
	int     burst_left = 0;
	logic   key_level [NUM_KEYS];

	button_click_classifier_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.key_index  (key_index),
		.key_active (key_active),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// Key model: one item in, the event it returns out
	function automatic event_t classify_item(op_t op, logic [KEY_IDX_W-1:0] key, logic act);
		event_t res;
		int k;
		res = EV_NONE;
		if (key < NUM_KEYS) begin
			k = int'(key);
			if (op == OP_READ) begin
				res = key_latch[k];
				key_latch[k] = EV_NONE;
			end else begin
				case (key_phase[k])
					PH_DEB1: begin
						if (act) begin
							key_phase[k] = PH_HOLD;
							key_ticks[k] = '0;
						end else
							key_phase[k] = PH_IDLE;
					end
					PH_HOLD: begin
						if (!act) begin
							key_phase[k] = PH_REL;
							key_ticks[k] = '0;
						end else if (key_ticks[k] > long_limit) begin
							res = EV_LONG;
							key_phase[k] = PH_WAIT_LONG;
						end else if (key_ticks[k] != '1)
							key_ticks[k]++;
					end
					PH_REL: begin
						if (act)
							key_phase[k] = PH_DEB2;
						else if (key_ticks[k] > short_limit) begin
							res = EV_SINGLE;
							key_phase[k] = PH_IDLE;
						end else if (key_ticks[k] != '1)
							key_ticks[k]++;
					end
					PH_DEB2: begin
						if (act) begin
							res = EV_DOUBLE;
							key_phase[k] = PH_WAIT_DBL;
						end else
							key_phase[k] = PH_REL;
					end
					PH_WAIT_DBL: begin
						if (!act)
							key_phase[k] = PH_IDLE;
					end
					PH_WAIT_LONG: begin
						if (!act) begin
							res = EV_LONG_REL;
							key_phase[k] = PH_IDLE;
						end
					end
					// idle, and the unused phase behaves the same
					default: key_phase[k] = act ? PH_DEB1 : PH_IDLE;
				endcase
				if (res != EV_NONE)
					key_latch[k] = res;
			end
		end
		return res;
	endfunction

	task automatic flag_mismatch(string what);
		error_count++;
		if (error_count <= 40)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Sender pacing: bursts of random length, random gaps between them
	task automatic pace();
		int gap;
		if (!burst_mode)
			return;
		if (burst_left > 0)
			burst_left--;
		else begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(0, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Offer one item, wait for its acceptance, record the predicted event
	task automatic send_item(op_t op, logic [KEY_IDX_W-1:0] key, logic act);
		operation <= op;
		key_index <= key;
		key_active <= act;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_events.push_back(classify_item(op, key, act));
		if (key < NUM_KEYS)
			useful_items++;
		pace();
	endtask

	task automatic scan_run(logic [KEY_IDX_W-1:0] key, logic act, int n);
		repeat (n) send_item(OP_SCAN, key, act);
	endtask

	// Stop offering and wait until every predicted event has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_events.size() != 0);
	endtask

	// Both thresholds are written back to back while the block is idle
	task automatic set_thresholds(count_t long_val, count_t short_val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LONG_PRESS;
		cfg_data <= long_val;
		@(posedge clk);
		cfg_index <= CFG_SHORT_RELEASE;
		cfg_data <= short_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		long_limit = long_val;
		short_limit = short_val;
	endtask

	// Press and release runs with random lengths around the thresholds, plus reads and noise
	task automatic run_presses(int n);
		int stop;
		int r;
		int k;
		int lim;
		int len;
		logic lvl;
		stop = useful_items + n;
		while (useful_items < stop) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				send_item(OP_READ, KEY_IDX_W'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)));
			else if (r < 10)
				send_item(op_t'(1'($urandom_range(0, 1))), KEY_IDX_W'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)));
			else begin
				k = $urandom_range(0, NUM_KEYS - 1);
				lvl = ~key_level[k];
				key_level[k] = lvl;
				lim = lvl ? int'(long_limit) : int'(short_limit);
				if (lim > 40)
					lim = 40;
				len = $urandom_range(1, lim + 4);
				scan_run(KEY_IDX_W'(k), lvl, len);
				if ($urandom_range(0, 2) == 0)
					send_item(OP_READ, KEY_IDX_W'(k), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Thresholds as they come out of reset
	task automatic test_reset_thresholds();
		burst_mode = 1'b1;
		stall_mode <= STALL_LIGHT;
		scan_run(3, 1'b1, 2);
		while (key_phase[3] != PH_WAIT_LONG)
			send_item(OP_SCAN, 3, 1'b1);
		send_item(OP_SCAN, 3, 1'b0);
		send_item(OP_READ, 3, 1'b0);
		scan_run(3, 1'b1, 2);
		send_item(OP_SCAN, 3, 1'b0);
		while (key_phase[3] == PH_REL)
			send_item(OP_SCAN, 3, 1'b0);
		send_item(OP_READ, 3, 1'b1);
	endtask

	// Short hand-built gestures: every event, glitches, bounce, keys out of range
	task automatic test_directed_sequences();
		set_thresholds(16'd2, 16'd1);
		burst_mode = 1'b0;
		stall_mode <= STALL_NONE;
		send_item(OP_READ, 0, 1'b1);
		send_item(OP_READ, 7, 1'b0);
		send_item(OP_SCAN, 5, 1'b1);
		send_item(OP_SCAN, 6, 1'b1);
		send_item(OP_SCAN, 7, 1'b0);
		// one-tick glitch
		send_item(OP_SCAN, 0, 1'b1);
		send_item(OP_SCAN, 0, 1'b0);
		// single click
		scan_run(0, 1'b1, 2);
		scan_run(0, 1'b0, 4);
		send_item(OP_READ, 0, 1'b0);
		// double click with a bounce while released
		scan_run(1, 1'b1, 2);
		send_item(OP_SCAN, 1, 1'b0);
		send_item(OP_SCAN, 1, 1'b1);
		send_item(OP_SCAN, 1, 1'b0);
		scan_run(1, 1'b1, 2);
		send_item(OP_SCAN, 1, 1'b0);
		send_item(OP_READ, 1, 1'b0);
		// long press, long release, read twice
		scan_run(2, 1'b1, 6);
		send_item(OP_SCAN, 2, 1'b0);
		send_item(OP_READ, 2, 1'b0);
		send_item(OP_READ, 2, 1'b0);
	endtask

	// Receiver holds off for a long stretch while items keep coming
	task automatic test_output_holdoff();
		set_thresholds(16'd3, 16'd2);
		burst_mode = 1'b0;
		stall_mode <= STALL_NONE;
		holdoff_len <= 150;
		run_presses(40);
	endtask

	// Sender pauses mid-stream until everything has come back
	task automatic test_drain_pause();
		burst_mode = 1'b1;
		stall_mode <= STALL_PERIODIC;
		run_presses(30);
		wait_drained();
		run_presses(30);
	endtask

	// Random gestures under several threshold settings and pacing modes
	task automatic test_random_presses();
		int p;
		for (p = 0; p < 6; p++) begin
			if (p == 0)
				set_thresholds(16'd0, 16'd0);
			else if (p == 1)
				set_thresholds(16'd3, 16'd1);
			else
				set_thresholds(count_t'($urandom_range(0, 15)),
					count_t'($urandom_range(0, 10)));
			burst_mode = (p % 3) != 2;
			stall_mode <= p % 4;
			run_presses(30);
		end
	endtask

	// Receiver stall: long hold-off first, else the current pattern
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (holdoff_len != 0) begin
			out_stall <= 1'b1;
			holdoff_len <= holdoff_len - 1;
		end else begin
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_PERIODIC: out_stall <= (stall_phase % 7) < 3;
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0)
				flag_mismatch($sformatf("event_res %0d with nothing pending", event_res));
			else begin
				next_event = pending_events.pop_front();
				if (event_res !== next_event)
					flag_mismatch($sformatf("event_res %0d, predicted %0d",
						event_res, next_event));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("[button_click_classifier_core] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_SCAN;
		key_index = '0;
		key_active = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LONG_PRESS;
		cfg_data = '0;
		long_limit = 16'd1000;
		short_limit = 16'd300;
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_phase[k] = PH_IDLE;
			key_ticks[k] = '0;
			key_latch[k] = EV_NONE;
			key_level[k] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_thresholds();
		test_directed_sequences();
		test_output_holdoff();
		test_drain_pause();
		test_random_presses();

		stall_mode <= STALL_NONE;
		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[button_click_classifier_core] OK");
		else
			$display("[button_click_classifier_core] ERROR");
		$finish;
	end

endmodule
